// File: rtl/stereo_strip_space_point_assert.svh
// Assertion macros shared by the space point modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STEREO_STRIP_SPACE_POINT_ASSERT_SVH
`define STEREO_STRIP_SPACE_POINT_ASSERT_SVH
`define SSSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SSSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/sssp_pkg.sv
// Package for the stereo strip space point builder.
// Holds item types, status and register codes, and controller types.
`timescale 1ns / 1ps
package sssp_pkg;

  typedef struct packed {
    logic               action;
    logic [2:0]         plane_id;
    logic [3:0]         module_id;
    logic [1:0]         sensor_id;
    logic [2:0]         row_id;
    logic signed [23:0] cluster_charge;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               point_valid;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [27:0] total_charge;
    logic [1:0]         grouped_sensor;
  } out_item_t;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_PLANE  = 3'd1;
  localparam logic [2:0] ST_MODULE = 3'd2;
  localparam logic [2:0] ST_SENSOR = 3'd3;
  localparam logic [2:0] ST_ROW    = 3'd4;
  localparam logic [2:0] ST_FULL   = 3'd5;

  localparam logic REG_TAN = 1'b0;
  localparam logic REG_COT = 1'b1;

  localparam logic [29:0] TAN_RST = 30'd21477152;
  localparam logic [31:0] COT_RST = 32'd3276254;

  localparam logic signed [27:0] CHG_MAX = 28'sh7FFFFFF;
  localparam logic signed [27:0] CHG_MIN = 28'sh8000000;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DLOAD, S_DIV, S_MEAN, S_DIFF, S_MUL, S_FIN, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic dload;
    logic div_step;
    logic mean;
    logic diff;
    logic mul;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_pt;
  } sts_t;

endpackage

// File: rtl/sssp_ctrl.sv
// Controller of the space point builder: sequences check, divide and
// multiply steps. Depends on sssp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "stereo_strip_space_point_assert.svh"
module sssp_ctrl #(
  parameter int MAX_CLUSTERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sssp_pkg::cmd_t cmd,
  input  sssp_pkg::sts_t sts
);
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W = 32 + CNT_W;
  localparam int DC_W  = $clog2(SUM_W);

  sssp_pkg::state_t state_r, state_nxt;
  logic [DC_W-1:0]  cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             div_last;

  assign div_last  = (cnt_r == DC_W'(SUM_W - 1));
  assign in_ready  = (state_r == sssp_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sssp_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      sssp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sssp_pkg::S_CHECK;
        end
      end
      sssp_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.need_pt ? sssp_pkg::S_DLOAD : sssp_pkg::S_DONE;
      end
      sssp_pkg::S_DLOAD: begin
        cmd.dload = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sssp_pkg::S_DIV;
      end
      sssp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (div_last) begin
          state_nxt = sssp_pkg::S_MEAN;
        end
      end
      sssp_pkg::S_MEAN: begin
        cmd.mean  = 1'b1;
        state_nxt = sssp_pkg::S_DIFF;
      end
      sssp_pkg::S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = sssp_pkg::S_MUL;
      end
      sssp_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sssp_pkg::S_FIN;
      end
      sssp_pkg::S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sssp_pkg::S_DONE;
      end
      sssp_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = sssp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sssp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  `SSSP_ASSERT_IMP(a_ready_idle, in_ready, state_r == sssp_pkg::S_IDLE, "ready outside idle")
  `SSSP_ASSERT_NXT(a_div_end, state_r == sssp_pkg::S_DIV && div_last, state_r == sssp_pkg::S_MEAN, "divide did not end")
  `SSSP_ASSERT_NXT(a_out_load, state_r == sssp_pkg::S_DONE && (!out_valid_r || out_ready), out_valid_r && state_r == sssp_pkg::S_IDLE, "result not loaded")
endmodule

// File: rtl/sssp_dp.sv
// Datapath of the space point builder: point state, six divider lanes,
// multipliers and the result register. Depends on sssp_pkg.
`timescale 1ns / 1ps
module sssp_dp #(
  parameter int MAX_CLUSTERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sssp_pkg::cmd_t     cmd,
  output sssp_pkg::sts_t     sts,
  input  sssp_pkg::in_item_t in_data,
  input  logic [29:0]        tan_stereo,
  input  logic [31:0]        cot_stereo,
  output sssp_pkg::out_item_t out_data
);
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W = 32 + CNT_W;

  sssp_pkg::in_item_t  it_r;
  sssp_pkg::out_item_t out_r;

  logic [CNT_W-1:0]         cc_r, fcnt_r, bcnt_r;
  logic [2:0]               plane_r, row_r, status_r;
  logic [3:0]               module_r;
  logic [1:0]               group_r;
  logic signed [SUM_W-1:0]  fsum_r [3];
  logic signed [SUM_W-1:0]  bsum_r [3];
  logic signed [27:0]       chg_r;
  logic signed [31:0]       lpos_r [3];
  logic                     have_r;

  logic [SUM_W-1:0]         dvd_r [6];
  logic [CNT_W-1:0]         rem_r [6];
  logic                     neg_r [6];
  logic signed [31:0]       mean_r [6];
  logic signed [32:0]       dx_r, dy_r, sx_r, sy_r, sz_r;
  logic signed [63:0]       px_r;
  logic signed [49:0]       pyh_r, pyl_r;

  // Admission check and next point state.
  logic                     open;
  logic [1:0]               grp;
  logic [2:0]               status_c;
  logic [CNT_W-1:0]         cc_b, fcnt_b, bcnt_b, fcnt_n, bcnt_n;
  logic signed [27:0]       chg_b, chg_n;
  logic signed [28:0]       chg_w;
  logic                     use_pos, front;
  logic signed [31:0]       pos [3];
  logic signed [31:0]       x_fin, y_fin, z_fin;

  assign open  = it_r.action || (cc_r == '0);
  assign grp   = {it_r.sensor_id[1], 1'b0};
  assign pos[0] = it_r.pos_x;
  assign pos[1] = it_r.pos_y;
  assign pos[2] = it_r.pos_z;
  assign use_pos = (it_r.cluster_charge != '0);
  assign front   = it_r.sensor_id[0];

  always_comb begin
    if (open) begin
      status_c = sssp_pkg::ST_OK;
    end else if (it_r.plane_id != plane_r) begin
      status_c = sssp_pkg::ST_PLANE;
    end else if (it_r.module_id != module_r) begin
      status_c = sssp_pkg::ST_MODULE;
    end else if (grp != group_r) begin
      status_c = sssp_pkg::ST_SENSOR;
    end else if (it_r.row_id != row_r) begin
      status_c = sssp_pkg::ST_ROW;
    end else if (cc_r >= CNT_W'(MAX_CLUSTERS)) begin
      status_c = sssp_pkg::ST_FULL;
    end else begin
      status_c = sssp_pkg::ST_OK;
    end
  end

  assign cc_b   = open ? '0 : cc_r;
  assign fcnt_b = open ? '0 : fcnt_r;
  assign bcnt_b = open ? '0 : bcnt_r;
  assign chg_b  = open ? '0 : chg_r;
  assign fcnt_n = fcnt_b + CNT_W'(use_pos && front);
  assign bcnt_n = bcnt_b + CNT_W'(use_pos && !front);
  assign chg_w  = {chg_b[27], chg_b} + {{5{it_r.cluster_charge[23]}}, it_r.cluster_charge};

  always_comb begin
    if (chg_w[28] != chg_w[27]) begin
      chg_n = chg_w[28] ? sssp_pkg::CHG_MIN : sssp_pkg::CHG_MAX;
    end else begin
      chg_n = chg_w[27:0];
    end
  end

  assign sts.need_pt = (status_c == sssp_pkg::ST_OK) && (fcnt_n != '0) && (bcnt_n != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r     <= '0;
      fcnt_r   <= '0;
      bcnt_r   <= '0;
      plane_r  <= '0;
      module_r <= '0;
      group_r  <= '0;
      row_r    <= '0;
      chg_r    <= '0;
      have_r   <= 1'b0;
      status_r <= sssp_pkg::ST_OK;
      for (int i = 0; i < 3; i++) begin
        fsum_r[i] <= '0;
        bsum_r[i] <= '0;
        lpos_r[i] <= '0;
      end
    end else if (cmd.check) begin
      status_r <= status_c;
      if (status_c == sssp_pkg::ST_OK) begin
        cc_r     <= cc_b + 1'b1;
        fcnt_r   <= fcnt_n;
        bcnt_r   <= bcnt_n;
        chg_r    <= chg_n;
        plane_r  <= it_r.plane_id;
        module_r <= it_r.module_id;
        group_r  <= grp;
        row_r    <= it_r.row_id;
        for (int i = 0; i < 3; i++) begin
          fsum_r[i] <= (open ? '0 : fsum_r[i])
                       + ((use_pos && front) ? SUM_W'(pos[i]) : '0);
          bsum_r[i] <= (open ? '0 : bsum_r[i])
                       + ((use_pos && !front) ? SUM_W'(pos[i]) : '0);
        end
        if (open) begin
          have_r <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            lpos_r[i] <= '0;
          end
        end
      end
    end else if (cmd.fin) begin
      have_r    <= 1'b1;
      lpos_r[0] <= x_fin;
      lpos_r[1] <= y_fin;
      lpos_r[2] <= z_fin;
    end
  end

  // Six restoring divider lanes: front x, y, z then back x, y, z.
  logic signed [SUM_W-1:0] lane_sum [6];
  logic [CNT_W-1:0]        lane_den [6];
  logic [CNT_W:0]          lane_sh  [6];
  logic                    lane_q   [6];
  logic [SUM_W-1:0]        lane_qn  [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_sum[i]     = fsum_r[i];
      lane_sum[i + 3] = bsum_r[i];
      lane_den[i]     = fcnt_r;
      lane_den[i + 3] = bcnt_r;
    end
    for (int i = 0; i < 6; i++) begin
      lane_sh[i] = {rem_r[i], dvd_r[i][SUM_W-1]};
      lane_q[i]  = (lane_sh[i] >= {1'b0, lane_den[i]});
      lane_qn[i] = neg_r[i] ? (~dvd_r[i] + 1'b1) : dvd_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      if (cmd.dload) begin
        neg_r[i] <= lane_sum[i][SUM_W-1];
        dvd_r[i] <= lane_sum[i][SUM_W-1] ? (~lane_sum[i] + 1'b1) : lane_sum[i];
        rem_r[i] <= '0;
      end else if (cmd.div_step) begin
        dvd_r[i] <= {dvd_r[i][SUM_W-2:0], lane_q[i]};
        rem_r[i] <= lane_q[i] ? CNT_W'(lane_sh[i] - {1'b0, lane_den[i]})
                              : lane_sh[i][CNT_W-1:0];
      end
      if (cmd.mean) begin
        mean_r[i] <= lane_qn[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx_r <= {mean_r[3][31], mean_r[3]} - {mean_r[0][31], mean_r[0]};
      dy_r <= {mean_r[4][31], mean_r[4]} - {mean_r[1][31], mean_r[1]};
      sx_r <= {mean_r[0][31], mean_r[0]} + {mean_r[3][31], mean_r[3]};
      sy_r <= {mean_r[1][31], mean_r[1]} + {mean_r[4][31], mean_r[4]};
      sz_r <= {mean_r[2][31], mean_r[2]} + {mean_r[5][31], mean_r[5]};
    end
    if (cmd.mul) begin
      px_r  <= 64'(dy_r * $signed({1'b0, tan_stereo}));
      pyh_r <= 50'(dx_r * $signed({1'b0, cot_stereo[31:16]}));
      pyl_r <= 50'(dx_r * $signed({1'b0, cot_stereo[15:0]}));
    end
  end

  // Final combine: ceiling of the scaled correction, half the difference,
  // then saturation to 32 bits.
  logic signed [63:0] npx, cx, ax, xs;
  logic signed [51:0] npy, cy, ay, ys;

  always_comb begin
    npx = -px_r;
    cx  = -(npx >>> 30);
    ax  = {{31{sx_r[32]}}, sx_r} - cx;
    xs  = ax >>> 1;
    npy = -{{2{pyl_r[49]}}, pyl_r};
    cy  = -(npy >>> 16);
    ay  = {{19{sy_r[32]}}, sy_r} - {{2{pyh_r[49]}}, pyh_r} - cy;
    ys  = ay >>> 1;
    if ((&xs[63:31]) || !(|xs[63:31])) begin
      x_fin = xs[31:0];
    end else begin
      x_fin = xs[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    if ((&ys[51:31]) || !(|ys[51:31])) begin
      y_fin = ys[31:0];
    end else begin
      y_fin = ys[51] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    z_fin = sz_r[32:1];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status         <= status_r;
      out_r.point_valid    <= have_r;
      out_r.point_x        <= lpos_r[0];
      out_r.point_y        <= lpos_r[1];
      out_r.point_z        <= lpos_r[2];
      out_r.total_charge   <= chg_r;
      out_r.grouped_sensor <= group_r;
    end
  end

  assign out_data = out_r;
endmodule

// File: rtl/stereo_strip_space_point.sv
// Channel   Signals                      Direction
// in        in_valid/in_ready/in_data    cluster item into the block
// out       out_valid/out_ready/out_data result item out of the block
// cfg       cfg_we/cfg_idx/cfg_wdata     register writes, no read-back
// A rejected item, or one that leaves a side empty, passes idle, check, done.
// An item that yields a point also passes divider load, the six bit-serial
// mean divisions of 32 + clog2(MAX_CLUSTERS + 1) steps, mean, diff, mul, fin.
// One item is in work at a time; a waiting result does not block the next
// item, which stalls only at its end if the result is still untaken.
// Reset is synchronous and needs no clearing pass.
// Top level of the space point builder; depends on sssp_pkg, sssp_ctrl, sssp_dp.
`timescale 1ns / 1ps
module stereo_strip_space_point #(
  parameter int MAX_CLUSTERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sssp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sssp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [31:0]         cfg_wdata
);
  logic [29:0]    tan_r;
  logic [31:0]    cot_r;
  sssp_pkg::cmd_t cmd;
  sssp_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tan_r <= sssp_pkg::TAN_RST;
      cot_r <= sssp_pkg::COT_RST;
    end else if (cfg_we) begin
      if (cfg_idx == sssp_pkg::REG_TAN) begin
        tan_r <= cfg_wdata[29:0];
      end else begin
        cot_r <= cfg_wdata;
      end
    end
  end

  sssp_ctrl #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sssp_dp #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_data),
    .tan_stereo (tan_r),
    .cot_stereo (cot_r),
    .out_data   (out_data)
  );
endmodule
